### rtl/core/lhrb_pkg.sv
// Shared constants, codes and handshake structs for the line history ring buffer.
// Depends on nothing; every other file in rtl/core imports it except lhrb_ram.
package lhrb_pkg;

    // Sizing of the ring and of one line
    localparam int DEPTH    = 16;
    localparam int LINE_LEN = 256;

    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int LEN_W       = $clog2(LINE_LEN);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DIST_W      = SLOT_W + 1;
    localparam int STORE_AW    = SLOT_W + LEN_W;
    localparam int STORE_WORDS = DEPTH * (2 ** LEN_W);

    // Fixed port field widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int RSLOT_W  = 4;
    localparam int ROFF_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OSLOT_W  = 4;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_PREV  = 3'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Add status codes
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic loop_start;
        logic cmp_step;
        logic copy_step;
        logic end_empty;
        logic end_dup;
        logic end_store;
        logic load_out;
    } lhrb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic commit_item;
        logic stg_empty;
        logic dup_cand;
        logic loop_done;
        logic mismatch;
        logic out_free;
    } lhrb_sts_t;

endpackage

### rtl/core/line_history_ring_buffer_unit.sv
// Line history ring buffer: one transfer in, one result transfer out per item.
// Prev, next, cursor reset, read, spare ops and non-final add bytes go straight to the
// result register; one item is in flight at a time. Commit (L = staged length) stores
// nothing when empty; else it copies the L staged bytes, or, when the newest line has
// the same length, first compares them with it and copies only if that compare fails.
// Reset (rst_n low, async) empties the ring and clears per-slot line lengths at once.
module line_history_ring_buffer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lhrb_pkg::OP_W-1:0]     op,
    input  logic [lhrb_pkg::BYTE_W-1:0]   line_byte,
    input  logic                          line_end,
    input  logic [lhrb_pkg::RSLOT_W-1:0]  read_slot,
    input  logic [lhrb_pkg::ROFF_W-1:0]   read_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lhrb_pkg::STATUS_W-1:0] add_status,
    output logic                          found,
    output logic [lhrb_pkg::OSLOT_W-1:0]  slot,
    output logic [lhrb_pkg::BYTE_W-1:0]   data_byte,
    output logic [lhrb_pkg::COUNT_W-1:0]  entry_count
);
    import lhrb_pkg::*;

    // The controller walks each item: accept, optional commit (compare with the
    // newest line, then copy), then load the result register. The result register
    // parts the two sides, so a waiting result never blocks the next input transfer
    // from being accepted once the controller is back in idle.
    lhrb_cmd_t cmd;
    lhrb_sts_t sts;

    lhrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stored lines keep their length per slot; bytes past that length read as
    // zero, which stands in for zero padding and for a store cleared at reset.
    lhrb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .line_byte   (line_byte),
        .line_end    (line_end),
        .read_slot   (read_slot),
        .read_offset (read_offset),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .add_status  (add_status),
        .found       (found),
        .slot        (slot),
        .data_byte   (data_byte),
        .entry_count (entry_count)
    );

    // Count never exceeds the ring depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(entry_count) <= 32'(DEPTH)))
        else $error("entry_count beyond ring depth");

    // Only one item in flight: an accepted transfer stalls the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in flight");

    // A browse hit never comes with an add status or read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> ((add_status == ST_NONE) && (data_byte == '0)))
        else $error("browse result mixed with add or read result");

endmodule

### rtl/core/lhrb_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependency.
module lhrb_ram #(
    parameter int DATA_W = 8,
    parameter int WORDS  = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lhrb_ctrl.sv
// Sequencing state machine for the line history ring buffer.
// Depends on lhrb_pkg; drives lhrb_dp through lhrb_cmd_t and reads lhrb_sts_t.
module lhrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lhrb_pkg::lhrb_sts_t sts,
    output lhrb_pkg::lhrb_cmd_t cmd
);
    import lhrb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COMMIT = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_COPY   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.commit_item ? S_COMMIT : S_FINISH;
                end
            end
            S_COMMIT:
            begin
                if (sts.stg_empty)
                begin
                    cmd.end_empty = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.loop_start = 1'b1;
                    state_next     = sts.dup_cand ? S_CMP : S_COPY;
                end
            end
            S_CMP:
            begin
                if (!sts.loop_done)
                begin
                    cmd.cmp_step = 1'b1;
                end
                else if (sts.mismatch)
                begin
                    cmd.loop_start = 1'b1;
                    state_next     = S_COPY;
                end
                else
                begin
                    cmd.end_dup = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_COPY:
            begin
                if (!sts.loop_done)
                begin
                    cmd.copy_step = 1'b1;
                end
                else
                begin
                    cmd.end_store = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/lhrb_dp.sv
// Datapath: staging line, line store, ring pointers, browse cursor, result register.
// Depends on lhrb_pkg and lhrb_ram; commanded by lhrb_ctrl.
module lhrb_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lhrb_pkg::lhrb_cmd_t                  cmd,
    output lhrb_pkg::lhrb_sts_t                  sts,
    input  logic [lhrb_pkg::OP_W-1:0]            op,
    input  logic [lhrb_pkg::BYTE_W-1:0]          line_byte,
    input  logic                                 line_end,
    input  logic [lhrb_pkg::RSLOT_W-1:0]         read_slot,
    input  logic [lhrb_pkg::ROFF_W-1:0]          read_offset,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [lhrb_pkg::STATUS_W-1:0]        add_status,
    output logic                                 found,
    output logic [lhrb_pkg::OSLOT_W-1:0]         slot,
    output logic [lhrb_pkg::BYTE_W-1:0]          data_byte,
    output logic [lhrb_pkg::COUNT_W-1:0]         entry_count
);
    import lhrb_pkg::*;

    logic [LEN_W-1:0]    stg_len_reg, stg_len_next;
    logic                stg_closed_reg, stg_closed_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [LEN_W-1:0]    newest_len_reg, newest_len_next;
    logic [LEN_W-1:0]    slot_len_reg [DEPTH];
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [LEN_W-1:0]    rd_idx_reg;
    logic                mismatch_reg, mismatch_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic                read_hit_reg, read_hit_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] add_status_reg;
    logic                found_out_reg;
    logic [OSLOT_W-1:0]  slot_out_reg;
    logic [BYTE_W-1:0]   data_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic [SLOT_W-1:0]   newest;
    logic [SLOT_W-1:0]   prev_cur;
    logic [SLOT_W-1:0]   next_cur;
    logic [DIST_W-1:0]   ring_gap;
    logic                issue;
    logic                read_in_range;

    logic                stg_we;
    logic [BYTE_W-1:0]   stg_rdata;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic                store_re;
    logic [STORE_AW-1:0] store_raddr;
    logic [BYTE_W-1:0]   store_rdata;

    // Ring and cursor arithmetic
    assign newest   = (wslot_reg == '0) ? SLOT_W'(DEPTH - 1) : wslot_reg - 1'b1;
    assign prev_cur = !cur_valid_reg ? newest :
                      (cur_reg == '0) ? SLOT_W'(DEPTH - 1) : cur_reg - 1'b1;
    assign next_cur = (cur_reg == SLOT_W'(DEPTH - 1)) ? '0 : cur_reg + 1'b1;
    assign ring_gap = (wslot_reg >= prev_cur) ?
                      DIST_W'(wslot_reg) - DIST_W'(prev_cur) :
                      DIST_W'(wslot_reg) + DIST_W'(DEPTH) - DIST_W'(prev_cur);

    assign issue = (cmd.cmp_step || cmd.copy_step) && (idx_reg < stg_len_reg);

    assign read_in_range = (32'(read_slot) < 32'(DEPTH)) &&
                           (32'(read_offset) < 32'(LINE_LEN));

    assign stg_we = cmd.accept && (op == OP_ADD) && !stg_closed_reg &&
                    (line_byte != '0) && (32'(stg_len_reg) < 32'(LINE_LEN - 1));

    assign store_we    = cmd.copy_step && rd_valid_reg;
    assign store_waddr = {wslot_reg, rd_idx_reg};
    assign store_re    = (cmd.accept && (op == OP_READ)) || (cmd.cmp_step && issue);
    assign store_raddr = cmd.accept ? {SLOT_W'(read_slot), LEN_W'(read_offset)} :
                                      {newest, idx_reg};

    always_comb
    begin
        stg_len_next    = stg_len_reg;
        stg_closed_next = stg_closed_reg;
        stored_next     = stored_reg;
        wslot_next      = wslot_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        newest_len_next = newest_len_reg;
        idx_next        = idx_reg;
        rd_valid_next   = issue;
        mismatch_next   = mismatch_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        hit_slot_next   = hit_slot_reg;
        read_hit_next   = read_hit_reg;

        if (cmd.accept)
        begin
            status_next   = ST_NONE;
            found_next    = 1'b0;
            hit_slot_next = '0;
            read_hit_next = 1'b0;
            case (op)
                OP_ADD:
                begin
                    if (!stg_closed_reg)
                    begin
                        if (line_byte == '0)
                        begin
                            stg_closed_next = 1'b1;
                        end
                        else if (stg_we)
                        begin
                            stg_len_next = stg_len_reg + 1'b1;
                        end
                    end
                end
                OP_PREV:
                begin
                    if (stored_reg != '0)
                    begin
                        cur_next = prev_cur;
                        if (ring_gap > DIST_W'(stored_reg))
                        begin
                            cur_valid_next = 1'b0;
                        end
                        else
                        begin
                            cur_valid_next = 1'b1;
                            found_next     = 1'b1;
                            hit_slot_next  = prev_cur;
                        end
                    end
                end
                OP_NEXT:
                begin
                    if ((stored_reg != '0) && cur_valid_reg)
                    begin
                        cur_next = next_cur;
                        if (next_cur == wslot_reg)
                        begin
                            cur_valid_next = 1'b0;
                        end
                        else
                        begin
                            found_next    = 1'b1;
                            hit_slot_next = next_cur;
                        end
                    end
                end
                OP_RESET:
                begin
                    cur_valid_next = 1'b0;
                end
                OP_READ:
                begin
                    read_hit_next = read_in_range &&
                        (32'(read_offset) < 32'(slot_len_reg[SLOT_W'(read_slot)]));
                end
                default:
                begin
                end
            endcase
        end

        // Compare / copy loop: advance the issue index, check returned bytes
        if (cmd.loop_start)
        begin
            idx_next      = '0;
            rd_valid_next = 1'b0;
            mismatch_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.cmp_step && rd_valid_reg && (stg_rdata != store_rdata))
        begin
            mismatch_next = 1'b1;
        end

        if (cmd.end_empty || cmd.end_dup || cmd.end_store)
        begin
            stg_len_next    = '0;
            stg_closed_next = 1'b0;
        end
        if (cmd.end_empty)
        begin
            status_next = ST_EMPTY;
        end
        if (cmd.end_dup)
        begin
            status_next = ST_DUP;
        end
        if (cmd.end_store)
        begin
            status_next     = ST_STORED;
            wslot_next      = (wslot_reg == SLOT_W'(DEPTH - 1)) ? '0 : wslot_reg + 1'b1;
            newest_len_next = stg_len_reg;
            cur_valid_next  = 1'b0;
            if (32'(stored_reg) < 32'(DEPTH))
            begin
                stored_next = stored_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_len_reg    <= '0;
            stg_closed_reg <= 1'b0;
            stored_reg     <= '0;
            wslot_reg      <= '0;
            cur_reg        <= '0;
            cur_valid_reg  <= 1'b0;
            newest_len_reg <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            mismatch_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_len_reg[i] <= '0;
            end
        end
        else
        begin
            stg_len_reg    <= stg_len_next;
            stg_closed_reg <= stg_closed_next;
            stored_reg     <= stored_next;
            wslot_reg      <= wslot_next;
            cur_reg        <= cur_next;
            cur_valid_reg  <= cur_valid_next;
            newest_len_reg <= newest_len_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            mismatch_reg   <= mismatch_next;
            if (cmd.end_store)
            begin
                slot_len_reg[wslot_reg] <= stg_len_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= idx_reg;
        status_reg   <= status_next;
        found_reg    <= found_next;
        hit_slot_reg <= hit_slot_next;
        read_hit_reg <= read_hit_next;
        if (cmd.load_out)
        begin
            add_status_reg <= status_reg;
            found_out_reg  <= found_reg;
            slot_out_reg   <= OSLOT_W'(hit_slot_reg);
            data_out_reg   <= read_hit_reg ? store_rdata : '0;
            count_out_reg  <= COUNT_W'(stored_reg);
        end
    end

    lhrb_ram #(
        .DATA_W (BYTE_W),
        .WORDS  (LINE_LEN)
    ) u_stage_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_len_reg),
        .wdata (line_byte),
        .re    (issue),
        .raddr (idx_reg),
        .rdata (stg_rdata)
    );

    lhrb_ram #(
        .DATA_W (BYTE_W),
        .WORDS  (STORE_WORDS)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (stg_rdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    assign sts.commit_item = (op == OP_ADD) && line_end;
    assign sts.stg_empty   = (stg_len_reg == '0);
    assign sts.dup_cand    = (stored_reg != '0) && (stg_len_reg == newest_len_reg);
    assign sts.loop_done   = (idx_reg == stg_len_reg) && !rd_valid_reg;
    assign sts.mismatch    = mismatch_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign add_status  = add_status_reg;
    assign found       = found_out_reg;
    assign slot        = slot_out_reg;
    assign data_byte   = data_out_reg;
    assign entry_count = count_out_reg;

endmodule
